[design/camera_sector_visibility_test_top_macros.svh]
// Assertion macros for the camera sector visibility test checker.
// Expects signals named clock and reset in the scope of use.
`ifndef CAMERA_SECTOR_VISIBILITY_TEST_TOP_MACROS_SVH
`define CAMERA_SECTOR_VISIBILITY_TEST_TOP_MACROS_SVH

// same-cycle implication
`define CSVT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSVT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/csvt_pkg.sv]
// Shared constants, types and tables for the camera sector visibility test.
// No dependencies.
package csvt_pkg;

   localparam int ID_W       = 16;
   localparam int POS_W      = 24;
   localparam int DIFF_W     = POS_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int DIST_W     = 25;
   localparam int ANGLE_W    = 16;
   localparam int WEIGHT_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   localparam int SQRT_STAGES = SQ_W / 2;
   localparam int DIV_STAGES  = WEIGHT_W;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int CORDIC_MAX        = 24;
   localparam int CORDIC_W          = 36;
   localparam int ZACC_W            = 32;

   localparam logic [ANGLE_W-1:0] HALF_VIEW_RST = 16'd8192;
   localparam logic [DIST_W-1:0]  RANGE_RST     = 25'd51200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAMERA_ID   = 3'd0,
      CSR_CAMERA_X    = 3'd1,
      CSR_CAMERA_Y    = 3'd2,
      CSR_HEADING     = 3'd3,
      CSR_HALF_VIEW   = 3'd4,
      CSR_VIEW_RANGE  = 3'd5
   } csr_index_type;

   // atan(2^-i), 2^32 per turn
   localparam logic [ZACC_W-1:0] ATAN_TAB [CORDIC_MAX] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage

[design/csvt_if.sv]
// Valid/ready channel interfaces for node requests and visibility responses.
// Depends on csvt_pkg.
interface csvt_req_if;
   logic                              valid;
   logic                              ready;
   logic        [csvt_pkg::ID_W-1:0]  node_id;
   logic signed [csvt_pkg::POS_W-1:0] node_x;
   logic signed [csvt_pkg::POS_W-1:0] node_y;

   modport source  (output valid, node_id, node_x, node_y, input ready);
   modport sink    (input valid, node_id, node_x, node_y, output ready);
   modport monitor (input valid, ready, node_id, node_x, node_y);
endinterface

interface csvt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [csvt_pkg::ID_W-1:0]         result_id;
   logic                              visible;
   logic [csvt_pkg::DIST_W-1:0]       distance;
   logic [csvt_pkg::WEIGHT_W-1:0]     weight;

   modport source  (output valid, result_id, visible, distance, weight, input ready);
   modport sink    (input valid, result_id, visible, distance, weight, output ready);
   modport monitor (input valid, ready, result_id, visible, distance, weight);
endinterface

[design/camera_sector_visibility_test_top.sv]
// Camera sector visibility test. The whole pipeline stalls while a response
// waits; otherwise it takes one node per cycle. It returns one response per
// node, in order, after offset, square and sum registers, 25 one-bit square
// root stages (these set the depth), a test register and 16 divider stages.
// Configuration registers must only be written while the pipeline is empty.
// Depends on csvt_pkg, csvt_if, csvt_delay, csvt_sqrt, csvt_cordic, csvt_div.
module camera_sector_visibility_test_top #(
   parameter int CORDIC_STAGES = csvt_pkg::CORDIC_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   csvt_req_if.sink                           req_ch,
   csvt_rsp_if.source                         rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [csvt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [csvt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDW  = csvt_pkg::ID_W;
   localparam int PW   = csvt_pkg::POS_W;
   localparam int DFW  = csvt_pkg::DIFF_W;
   localparam int SQW  = csvt_pkg::SQ_W;
   localparam int DSW  = csvt_pkg::DIST_W;
   localparam int AW   = csvt_pkg::ANGLE_W;
   localparam int WW   = csvt_pkg::WEIGHT_W;
   localparam int LAT  = 3 + csvt_pkg::SQRT_STAGES + 1 + csvt_pkg::DIV_STAGES;
   localparam int ID_DLY  = csvt_pkg::SQRT_STAGES + 2;
   localparam int BRG_DLY = csvt_pkg::SQRT_STAGES + 1 - CORDIC_STAGES;
   localparam int SB_W    = IDW + 1 + DSW + 1;

   // configuration
   logic        [IDW-1:0] cam_id_ff;
   logic signed [PW-1:0]  cam_x_ff;
   logic signed [PW-1:0]  cam_y_ff;
   logic        [AW-1:0]  heading_ff;
   logic        [AW-1:0]  half_view_ff;
   logic        [DSW-1:0] range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_id_ff    <= '0;
         cam_x_ff     <= '0;
         cam_y_ff     <= '0;
         heading_ff   <= '0;
         half_view_ff <= csvt_pkg::HALF_VIEW_RST;
         range_ff     <= csvt_pkg::RANGE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            csvt_pkg::CSR_CAMERA_ID:  cam_id_ff    <= csr_wdata[IDW-1:0];
            csvt_pkg::CSR_CAMERA_X:   cam_x_ff     <= csr_wdata[PW-1:0];
            csvt_pkg::CSR_CAMERA_Y:   cam_y_ff     <= csr_wdata[PW-1:0];
            csvt_pkg::CSR_HEADING:    heading_ff   <= csr_wdata[AW-1:0];
            csvt_pkg::CSR_HALF_VIEW:  half_view_ff <= csr_wdata[AW-1:0];
            csvt_pkg::CSR_VIEW_RANGE: range_ff     <= csr_wdata[DSW-1:0];
            default: ;
         endcase
      end
   end

   // global advance; valid bits shift with the data
   logic           adv;
   logic [LAT-1:0] vld_ff;

   assign adv          = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_ch.valid};
      end
   end

   // stage 1: offsets
   logic        [IDW-1:0] id_s1_ff;
   logic signed [DFW-1:0] dx_s1_ff;
   logic signed [DFW-1:0] dy_s1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         id_s1_ff <= req_ch.node_id;
         dx_s1_ff <= {req_ch.node_x[PW-1], req_ch.node_x} - {cam_x_ff[PW-1], cam_x_ff};
         dy_s1_ff <= {req_ch.node_y[PW-1], req_ch.node_y} - {cam_y_ff[PW-1], cam_y_ff};
      end
   end

   // stage 2: squares, stage 3: sum
   logic signed [SQW-1:0] px_s2_ff;
   logic signed [SQW-1:0] py_s2_ff;
   logic        [SQW-1:0] sq_s3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         px_s2_ff <= dx_s1_ff * dx_s1_ff;
         py_s2_ff <= dy_s1_ff * dy_s1_ff;
         sq_s3_ff <= $unsigned(px_s2_ff) + $unsigned(py_s2_ff);
      end
   end

   logic [DSW-1:0] dist_c;
   logic [AW-1:0]  brg_raw;
   logic [AW-1:0]  brg;
   logic [IDW-1:0] id_d;

   csvt_sqrt u_sqrt (
      .clock  (clock),
      .en     (adv),
      .sq_i   (sq_s3_ff),
      .root_o (dist_c)
   );

   csvt_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock (clock),
      .en    (adv),
      .dx_i  (dx_s1_ff),
      .dy_i  (dy_s1_ff),
      .brg_o (brg_raw)
   );

   csvt_delay #(.W(AW), .D(BRG_DLY)) u_brg_dly (
      .clock (clock),
      .en    (adv),
      .d_i   (brg_raw),
      .q_o   (brg)
   );

   csvt_delay #(.W(IDW), .D(ID_DLY)) u_id_dly (
      .clock (clock),
      .en    (adv),
      .d_i   (id_s1_ff),
      .q_o   (id_d)
   );

   // sector test
   logic [AW-1:0] diff;
   logic [AW:0]   abs_diff;
   logic          vis_c;

   assign diff     = brg - heading_ff;
   assign abs_diff = diff[AW-1] ? ((AW+1)'(1) << AW) - {1'b0, diff} : {1'b0, diff};
   assign vis_c    = (id_d != cam_id_ff) && (dist_c <= range_ff) &&
                     (abs_diff <= {1'b0, half_view_ff});

   logic [IDW-1:0] id_ev_ff;
   logic           vis_ev_ff;
   logic [DSW-1:0] dist_ev_ff;
   logic [DSW-1:0] num_ev_ff;
   logic           dz_ev_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         id_ev_ff   <= id_d;
         vis_ev_ff  <= vis_c;
         dist_ev_ff <= dist_c;
         num_ev_ff  <= range_ff - dist_c;
         dz_ev_ff   <= (dist_c == '0);
      end
   end

   logic [WW-1:0]   quot;
   logic [SB_W-1:0] sb_out;

   csvt_div u_div (
      .clock (clock),
      .en    (adv),
      .num_i (num_ev_ff),
      .den_i (range_ff),
      .q_o   (quot)
   );

   csvt_delay #(.W(SB_W), .D(csvt_pkg::DIV_STAGES)) u_sb_dly (
      .clock (clock),
      .en    (adv),
      .d_i   ({id_ev_ff, vis_ev_ff, dist_ev_ff, dz_ev_ff}),
      .q_o   (sb_out)
   );

   logic           vis_o;
   logic           dz_o;

   assign vis_o = sb_out[DSW+1];
   assign dz_o  = sb_out[0];

   assign rsp_ch.valid     = vld_ff[LAT-1];
   assign rsp_ch.result_id = sb_out[SB_W-1 -: IDW];
   assign rsp_ch.visible   = vis_o;
   assign rsp_ch.distance  = sb_out[DSW:1];
   // distance zero means a full weight, which the fraction cannot show
   assign rsp_ch.weight    = !vis_o ? '0 : (dz_o ? '1 : quot);

endmodule

[design/csvt_delay.sv]
// Enabled register delay line for sideband data traveling beside a pipeline.
// No dependencies.
module csvt_delay #(
   parameter int W = 1,
   parameter int D = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d_i,
   output logic [W-1:0] q_o
);

   logic [W-1:0] tap_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d_i;
      end
   end

   for (genvar k = 1; k < D; k++) begin : g_tap
      always_ff @(posedge clock) begin
         if (en) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign q_o = tap_ff[D-1];

endmodule

[design/csvt_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on csvt_pkg.
module csvt_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [csvt_pkg::SQ_W-1:0]     sq_i,
   output logic [csvt_pkg::DIST_W-1:0]   root_o
);

   localparam int N     = csvt_pkg::SQRT_STAGES;
   localparam int SQ_W  = csvt_pkg::SQ_W;
   localparam int RT_W  = csvt_pkg::DIST_W;
   localparam int REM_W = RT_W + 4;

   logic [SQ_W-1:0]  rad_ff  [N];
   logic [REM_W-1:0] rem_ff  [N];
   logic [RT_W-1:0]  root_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [SQ_W-1:0]  rad;
      logic [REM_W-1:0] rem;
      logic [RT_W-1:0]  root;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;

      if (k == 0) begin : g_first
         assign rad  = sq_i;
         assign rem  = '0;
         assign root = '0;
      end else begin : g_next
         assign rad  = rad_ff[k-1];
         assign rem  = rem_ff[k-1];
         assign root = root_ff[k-1];
      end

      // remainder stays below 2*root+1, so its top two bits are free
      assign rem_sh = {rem[REM_W-3:0], rad[SQ_W-1 -: 2]};
      assign trial  = {2'b00, root, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k] <= {rad[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff[k]  <= rem_sh - trial;
               root_ff[k] <= {root[RT_W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= rem_sh;
               root_ff[k] <= {root[RT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root_o = root_ff[N-1];

endmodule

[design/csvt_cordic.sv]
// Vectoring CORDIC: bearing of (dx, dy) as a 16-bit binary angle.
// Depends on csvt_pkg. The pipeline holds STAGES + 1 registers.
module csvt_cordic #(
   parameter int STAGES = csvt_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [csvt_pkg::DIFF_W-1:0]  dx_i,
   input  logic signed [csvt_pkg::DIFF_W-1:0]  dy_i,
   output logic        [csvt_pkg::ANGLE_W-1:0] brg_o
);

   localparam int W  = csvt_pkg::CORDIC_W;
   localparam int ZW = csvt_pkg::ZACC_W;
   localparam int DW = csvt_pkg::DIFF_W;
   localparam int AW = csvt_pkg::ANGLE_W;

   logic signed [W-1:0]  x_ff    [STAGES+1];
   logic signed [W-1:0]  y_ff    [STAGES+1];
   logic        [ZW-1:0] z_ff    [STAGES+1];
   logic                 zero_ff [STAGES+1];

   logic signed [W-1:0] x_pre;
   logic signed [W-1:0] y_pre;
   logic        [ZW-1:0] z_rnd;

   assign x_pre = {{(W-DW-8){dx_i[DW-1]}}, dx_i, 8'b0};
   assign y_pre = {{(W-DW-8){dy_i[DW-1]}}, dy_i, 8'b0};

   // left half plane: turn by a half turn first
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (dx_i == '0) && (dy_i == '0);
         if (dx_i[DW-1]) begin
            x_ff[0] <= -x_pre;
            y_ff[0] <= -y_pre;
            z_ff[0] <= {1'b1, {(ZW-1){1'b0}}};
         end else begin
            x_ff[0] <= x_pre;
            y_ff[0] <= y_pre;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [W-1:0] xs;
      logic signed [W-1:0] ys;

      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (!y_ff[i][W-1]) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + csvt_pkg::ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - csvt_pkg::ATAN_TAB[i];
            end
         end
      end
   end

   assign z_rnd = z_ff[STAGES] + {{(ZW-AW){1'b0}}, 1'b1, {(AW-1){1'b0}}};
   assign brg_o = zero_ff[STAGES] ? '0 : z_rnd[ZW-1 -: AW];

endmodule

[design/csvt_div.sv]
// Pipelined restoring divider for the weight fraction num/den, num < den.
// Depends on csvt_pkg. One quotient bit per stage.
module csvt_div (
   input  logic                            clock,
   input  logic                            en,
   input  logic [csvt_pkg::DIST_W-1:0]     num_i,
   input  logic [csvt_pkg::DIST_W-1:0]     den_i,
   output logic [csvt_pkg::WEIGHT_W-1:0]   q_o
);

   localparam int N  = csvt_pkg::DIV_STAGES;
   localparam int DW = csvt_pkg::DIST_W;
   localparam int QW = csvt_pkg::WEIGHT_W;

   logic [DW-1:0] r_ff [N];
   logic [QW-1:0] q_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [DW-1:0] r;
      logic [QW-1:0] q;
      logic [DW:0]   r2;

      if (k == 0) begin : g_first
         assign r = num_i;
         assign q = '0;
      end else begin : g_next
         assign r = r_ff[k-1];
         assign q = q_ff[k-1];
      end

      assign r2 = {r, 1'b0};

      always_ff @(posedge clock) begin
         if (en) begin
            if (r2 >= {1'b0, den_i}) begin
               r_ff[k] <= DW'(r2 - {1'b0, den_i});
               q_ff[k] <= {q[QW-2:0], 1'b1};
            end else begin
               r_ff[k] <= r2[DW-1:0];
               q_ff[k] <= {q[QW-2:0], 1'b0};
            end
         end
      end
   end

   assign q_o = q_ff[N-1];

endmodule

[design/csvt_checker.sv]
// Port-level checks for the camera sector visibility test top level.
// Depends on csvt_pkg and camera_sector_visibility_test_top_macros.svh.
`include "camera_sector_visibility_test_top_macros.svh"

module csvt_port_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [csvt_pkg::ID_W-1:0]       rsp_result_id,
   input logic                            rsp_visible,
   input logic [csvt_pkg::DIST_W-1:0]     rsp_distance,
   input logic [csvt_pkg::WEIGHT_W-1:0]   rsp_weight,
   input logic                            csr_wr_en,
   input logic [csvt_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [csvt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [csvt_pkg::DIST_W-1:0] range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= csvt_pkg::RANGE_RST;
      end else if (csr_wr_en && (csr_index == csvt_pkg::CSR_VIEW_RANGE)) begin
         range_ff <= csr_wdata[csvt_pkg::DIST_W-1:0];
      end
   end

   `CSVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable({rsp_result_id, rsp_visible, rsp_distance, rsp_weight}),
      "response changed while stalled")
   `CSVT_ASSERT_NOW(a_idle_ready, !rsp_valid, req_ready, "not ready with empty output")
   `CSVT_ASSERT_NOW(a_hidden_weight, rsp_valid && !rsp_visible, rsp_weight == '0,
      "nonzero weight on hidden node")
   `CSVT_ASSERT_NOW(a_vis_range, rsp_valid && rsp_visible, rsp_distance <= range_ff,
      "visible node beyond range")

endmodule

bind camera_sector_visibility_test_top csvt_port_checker u_csvt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_result_id (rsp_ch.result_id),
   .rsp_visible   (rsp_ch.visible),
   .rsp_distance  (rsp_ch.distance),
   .rsp_weight    (rsp_ch.weight),
   .csr_wr_en     (csr_wr_en),
   .csr_index     (csr_index),
   .csr_wdata     (csr_wdata)
);
